### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, disabled during reset.
`define LLB_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Same-cycle implication.
`define LLB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LLB_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/llb_pkg.sv
// ----------------------------------------------------------------------------
// llb_pkg
// Field widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package llb_pkg;

	localparam int LOAD_W    = 32;
	localparam int CNT_W     = 16;
	localparam int ATOM_W    = 16;
	localparam int TYPE_W    = 6;
	localparam int ACT_W     = 5;
	localparam int BKT_OUT_W = 4;

	localparam logic [ACT_W-1:0] ACTIVE_RST = 5'd16;

	localparam logic MODE_PLACE = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic scan_rd;
		logic update;
		logic finish_place;
		logic finish_clear;
		logic clear_loads;
		logic sweep_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic sweep_last;
		logic out_stall;
	} sts_t;

endpackage

`default_nettype wire

### sv/llb_if.sv
// ----------------------------------------------------------------------------
// llb stream interfaces
// Valid/ready channels for placement items and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface llb_in_if;
	import llb_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [TYPE_W-1:0] molecule_type;
	logic [ATOM_W-1:0] atoms_per_molecule;

	modport source (output valid, output mode, output molecule_type,
		output atoms_per_molecule, input ready);
	modport sink (input valid, input mode, input molecule_type,
		input atoms_per_molecule, output ready);
endinterface

interface llb_out_if;
	import llb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [BKT_OUT_W-1:0] chosen_bucket;
	logic [LOAD_W-1:0]    new_load;
	logic [CNT_W-1:0]     type_count;

	modport source (output valid, output chosen_bucket, output new_load,
		output type_count, input ready);
	modport sink (input valid, input chosen_bucket, input new_load,
		input type_count, output ready);
endinterface

`default_nettype wire

### sv/llb_ctrl.sv
// ----------------------------------------------------------------------------
// llb_ctrl
// Sequencer for scan, update, result and memory clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module llb_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	input  wire           in_mode,
	output logic          in_ready,
	output llb_pkg::cmd_t cmd,
	input  llb_pkg::sts_t sts
);
	import llb_pkg::*;

	typedef enum logic [6:0] {
		ST_SWEEP  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_COUNT  = 7'b0100000,
		ST_CLROUT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = (in_mode == MODE_CLEAR) ? ST_CLROUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last load read is compared in this cycle.
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (!sts.out_stall) begin
					cmd.finish_place = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLROUT: begin
				if (!sts.out_stall) begin
					cmd.finish_clear = 1'b1;
					cmd.clear_loads  = 1'b1;
					state_d = ST_SWEEP;
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/llb_dpath.sv
// ----------------------------------------------------------------------------
// llb_dpath
// Load memory scan, least-load tracking, count memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module llb_dpath #(
	parameter int BUCKETS   = 16,
	parameter int MOL_TYPES = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [llb_pkg::ACT_W-1:0]       cfg_wdata,
	input  llb_pkg::cmd_t                   cmd,
	output llb_pkg::sts_t                   sts,
	input  wire  [llb_pkg::TYPE_W-1:0]      in_type,
	input  wire  [llb_pkg::ATOM_W-1:0]      in_atoms,
	input  wire                             out_ready,
	output logic                            out_valid,
	output logic [llb_pkg::BKT_OUT_W-1:0]   out_bucket,
	output logic [llb_pkg::LOAD_W-1:0]      out_load,
	output logic [llb_pkg::CNT_W-1:0]       out_count
);
	import llb_pkg::*;

	localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int TW     = (MOL_TYPES > 1) ? $clog2(MOL_TYPES) : 1;
	localparam int AW     = BW + TW;
	localparam int CDEPTH = BUCKETS * (1 << TW);

	logic [ACT_W-1:0]  active_q;
	logic [TYPE_W-1:0] type_q;
	logic [ATOM_W-1:0] atoms_q;
	logic [BW-1:0]     scan_q;
	logic [BW-1:0]     last_idx;
	logic [AW-1:0]     sweep_q;

	logic [LOAD_W-1:0] load_mem [BUCKETS];
	logic [BUCKETS-1:0] load_vld_q;

	logic              rd_vld_s1;
	logic              rd_ok_s1;
	logic [BW-1:0]     rd_idx_s1;
	logic [LOAD_W-1:0] rd_data_s1;
	logic [LOAD_W-1:0] cur_load;

	logic [BW-1:0]     best_idx_q;
	logic [LOAD_W-1:0] best_load_q;

	logic [CNT_W-1:0]  cnt_mem [CDEPTH];
	logic [CNT_W-1:0]  cnt_rd_s1;
	logic [CNT_W-1:0]  cnt_inc;

	logic [TW+TYPE_W-1:0]    type_ext;
	logic [BW+BKT_OUT_W-1:0] bkt_ext;
	logic [AW-1:0]           cnt_addr;
	logic                    type_ok;
	logic [LOAD_W:0]         sum;
	logic [LOAD_W-1:0]       new_load;
	logic                    out_valid_q;
	logic [BKT_OUT_W-1:0]    bucket_q;
	logic [LOAD_W-1:0]       load_q;
	logic [CNT_W-1:0]        count_q;

	// Active bucket count, clipped to the range 1..BUCKETS, as the last scan index.
	always_comb begin
		if (active_q == '0) begin
			last_idx = '0;
		end else if (int'(active_q) > BUCKETS) begin
			last_idx = BW'(BUCKETS - 1);
		end else begin
			last_idx = BW'(active_q - ACT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RST;
			scan_q    <= '0;
			sweep_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (cmd.load_item) begin
				scan_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_q <= scan_q + BW'(1);
			end
			if (cmd.sweep_wr) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + AW'(1);
			end
			rd_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			type_q  <= in_type;
			atoms_q <= in_atoms;
		end
	end

	assign type_ext = {{TW{1'b0}}, type_q};
	assign type_ok  = int'(type_q) < MOL_TYPES;
	assign cnt_addr = {best_idx_q, type_ext[TW-1:0]};
	assign bkt_ext  = {{BKT_OUT_W{1'b0}}, best_idx_q};

	assign sum      = {1'b0, best_load_q} + (LOAD_W + 1)'(atoms_q);
	assign new_load = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
	assign cnt_inc  = (cnt_rd_s1 == '1) ? cnt_rd_s1 : cnt_rd_s1 + CNT_W'(1);

	// Load memory: one read port for the scan, one write port for the update.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			load_mem[best_idx_q] <= new_load;
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= load_mem[scan_q];
			rd_ok_s1   <= load_vld_q[scan_q];
			rd_idx_s1  <= scan_q;
		end
	end

	// An entry never written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_vld_q <= '0;
		end else if (cmd.clear_loads) begin
			load_vld_q <= '0;
		end else if (cmd.update) begin
			load_vld_q[best_idx_q] <= 1'b1;
		end
	end

	assign cur_load = rd_ok_s1 ? rd_data_s1 : '0;

	// Strict less-than keeps the lowest index on a tie.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && ((rd_idx_s1 == '0) || (cur_load < best_load_q))) begin
			best_load_q <= cur_load;
			best_idx_q  <= rd_idx_s1;
		end
	end

	// Per-bucket, per-type count memory.
	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			cnt_mem[sweep_q] <= '0;
		end else if (cmd.finish_place && type_ok) begin
			cnt_mem[cnt_addr] <= cnt_inc;
		end
		if (cmd.update) begin
			cnt_rd_s1 <= cnt_mem[cnt_addr];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish_place || cmd.finish_clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_place) begin
			bucket_q <= bkt_ext[BKT_OUT_W-1:0];
			load_q   <= new_load;
			count_q  <= type_ok ? cnt_inc : '0;
		end else if (cmd.finish_clear) begin
			bucket_q <= '0;
			load_q   <= '0;
			count_q  <= '0;
		end
	end

	assign sts.scan_last  = (scan_q == last_idx);
	assign sts.sweep_last = (sweep_q == AW'(CDEPTH - 1));
	assign sts.out_stall  = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_bucket = bucket_q;
	assign out_load   = load_q;
	assign out_count  = count_q;

endmodule

`default_nettype wire

### sv/least_loaded_bucket_assign_core.sv
// ----------------------------------------------------------------------------
// least_loaded_bucket_assign_core
// Greedy least-loaded assignment of molecule copies to compute buckets.
// ----------------------------------------------------------------------------
// Each place item is put into the active bucket with the smallest atom load,
// the lowest index winning a tie; the result gives that bucket, its new load
// and its new copy count for the item's type, both saturating. The bucket
// loads sit in a memory with one read port that the scan walks one bucket per
// cycle over the active bucket count (clipped to 1..BUCKETS); then come the
// compare of the last load read, the load update with the count read, and
// the count write with the result register load, which waits on a stalled output.
// A clear item returns an all-zero result and then sweeps the count memory,
// one entry per cycle, over BUCKETS * 2**ceil(log2 MOL_TYPES) entries (1024
// at the default sizes); the same sweep runs after reset. No item is taken
// during a sweep, but configuration writes are. A finished result waits in
// an output register, and the next item may be taken while it waits.
`default_nettype none

module least_loaded_bucket_assign_core #(
	parameter int BUCKETS   = 16,
	parameter int MOL_TYPES = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire  [llb_pkg::ACT_W-1:0]  cfg_wdata,
	llb_in_if.sink                     place,
	llb_out_if.source                  result
);
	import llb_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// The controller only sequences; all storage and arithmetic live in the datapath.
	llb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (place.valid),
		.in_mode  (place.mode),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	llb_dpath #(
		.BUCKETS   (BUCKETS),
		.MOL_TYPES (MOL_TYPES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.sts        (sts),
		.in_type    (place.molecule_type),
		.in_atoms   (place.atoms_per_molecule),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_bucket (result.chosen_bucket),
		.out_load   (result.new_load),
		.out_count  (result.type_count)
	);

	// A transfer on the input side happens only while the sequencer is idle.
	assign place.ready = in_ready;

endmodule

`default_nettype wire

### sv/llb_checker.sv
// ----------------------------------------------------------------------------
// llb_checker
// Port-level checks of the assignment core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module llb_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [3:0]  out_bucket,
	input wire [31:0] out_load,
	input wire [15:0] out_count
);

	logic [2:0] pending_q;

	// Items taken whose results have not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	`LLB_ASSERT_NXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready, "input ready after a transfer")
	`LLB_ASSERT_IMP(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(!in_ready), "result appeared while idle")
	`LLB_ASSERT(a_pending_bound, clk, arst_n, pending_q <= 3'd2, "more than two items in flight")
	`LLB_ASSERT_IMP(a_no_orphan_result, clk, arst_n, out_valid && out_ready, pending_q != 3'd0, "result without an item")
	`LLB_ASSERT_NXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_bucket) && $stable(out_load) && $stable(out_count), "stalled result changed")

endmodule

bind least_loaded_bucket_assign_core llb_checker u_llb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (place.valid),
	.in_ready   (place.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_bucket (result.chosen_bucket),
	.out_load   (result.new_load),
	.out_count  (result.type_count)
);

`default_nettype wire
